/* rtl/lidar_point_crop_and_ring_index_macros.svh */
// Assertion macros shared by the lidar crop and ring index RTL.
// Depends on the including module having clk and arst_n in scope.
`ifndef LIDAR_POINT_CROP_AND_RING_INDEX_MACROS_SVH
`define LIDAR_POINT_CROP_AND_RING_INDEX_MACROS_SVH
`ifndef SYNTHESIS
`define LPCR_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LPCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LPCR_ASSERT_IMPLIES(lbl, ante, cons)
`define LPCR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/lpcr_pkg.sv */
// Shared types and constants for the lidar crop and ring index pipeline.
// No dependencies.
package lpcr_pkg;
	localparam int CoordW      = 24;
	localparam int RadW        = 64;
	localparam int SqrtSteps   = 32;
	localparam int CordicSteps = 21;
	localparam int CordW       = 36;
	localparam int AngW        = 25;

	localparam logic [2:0] REG_BOX_X_MIN = 3'd0;
	localparam logic [2:0] REG_BOX_X_MAX = 3'd1;
	localparam logic [2:0] REG_BOX_Y_MIN = 3'd2;
	localparam logic [2:0] REG_BOX_Y_MAX = 3'd3;
	localparam logic [2:0] REG_MAX_RANGE = 3'd4;

	// atan(2^-i) in degrees, scaled by 2^16
	localparam logic [AngW-1:0] ATAN_Q16 [CordicSteps] = '{
		25'd2949120, 25'd1740967, 25'd919879, 25'd466945, 25'd234379, 25'd117265,
		25'd58666, 25'd29335, 25'd14668, 25'd7334, 25'd3667, 25'd1833, 25'd917,
		25'd458, 25'd229, 25'd115, 25'd57, 25'd29, 25'd14, 25'd7, 25'd4
	};

	typedef struct packed {
		logic signed [CoordW-1:0] box_x_min;
		logic signed [CoordW-1:0] box_x_max;
		logic signed [CoordW-1:0] box_y_min;
		logic signed [CoordW-1:0] box_y_max;
		logic [CoordW-2:0]        max_range;
	} cfg_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic [CoordW-1:0]        az;
		logic                     eoc;
		logic                     keep;
		logic                     zneg;
		logic                     zzero;
	} side_t;
endpackage

/* rtl/lpcr_front.sv */
// Front end: input capture, box test, squares and range test.
// Depends on lpcr_pkg.
module lpcr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [23:0]    x,
	input  logic signed [23:0]    y,
	input  logic signed [23:0]    z,
	input  logic                  eoc,
	input  lpcr_pkg::cfg_t        cfg,
	output logic                  valid_o,
	output lpcr_pkg::side_t       side_o,
	output logic [63:0]           rad_o
);
	import lpcr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [CoordW-1:0] x_s1, y_s1, z_s1;
	logic eoc_s1;
	side_t side_s2, side_s3, side_s4, side_s5;
	side_t side_n;
	logic [CoordW-1:0] ax_s2, ay_s2;
	logic box_s2, box_s3, box_s4;
	logic [47:0] sqx_s3, sqy_s3, sqz_s3, hsq_s4, sqz_s4;
	logic [45:0] mrsq_s3, mrsq_s4;
	logic [63:0] rad_s5;
	logic [48:0] dsq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign dsq = {1'b0, hsq_s4} + {1'b0, sqz_s4};

	// clear keep for points inside the box or beyond the range limit
	always_comb begin
		side_n      = side_s4;
		side_n.keep = !box_s4 && !(dsq > 49'(mrsq_s4));
	end

	always_ff @(posedge clk) begin
		x_s1   <= x;
		y_s1   <= y;
		z_s1   <= z;
		eoc_s1 <= eoc;

		side_s2.x     <= x_s1;
		side_s2.y     <= y_s1;
		side_s2.z     <= z_s1;
		side_s2.eoc   <= eoc_s1;
		side_s2.keep  <= 1'b1;
		side_s2.zneg  <= z_s1[CoordW-1];
		side_s2.zzero <= (z_s1 == '0);
		side_s2.az    <= z_s1[CoordW-1] ? CoordW'(-z_s1) : CoordW'(z_s1);
		ax_s2 <= x_s1[CoordW-1] ? CoordW'(-x_s1) : CoordW'(x_s1);
		ay_s2 <= y_s1[CoordW-1] ? CoordW'(-y_s1) : CoordW'(y_s1);
		box_s2 <= (x_s1 > cfg.box_x_min) && (x_s1 < cfg.box_x_max) &&
			(y_s1 > cfg.box_y_min) && (y_s1 < cfg.box_y_max);

		side_s3 <= side_s2;
		box_s3  <= box_s2;
		sqx_s3  <= 48'(ax_s2) * 48'(ax_s2);
		sqy_s3  <= 48'(ay_s2) * 48'(ay_s2);
		sqz_s3  <= 48'(side_s2.az) * 48'(side_s2.az);
		mrsq_s3 <= 46'(cfg.max_range) * 46'(cfg.max_range);

		side_s4 <= side_s3;
		box_s4  <= box_s3;
		hsq_s4  <= sqx_s3 + sqy_s3;
		sqz_s4  <= sqz_s3;
		mrsq_s4 <= mrsq_s3;

		side_s5 <= side_n;
		rad_s5  <= {hsq_s4, 16'b0};
	end

	assign valid_o = v_s5;
	assign side_o  = side_s5;
	assign rad_o   = rad_s5;
endmodule

/* rtl/lpcr_sqrt_stage.sv */
// One bit step of the pipelined restoring square root.
// Depends on lpcr_pkg.
module lpcr_sqrt_stage #(
	parameter int K = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_i,
	input  lpcr_pkg::side_t side_i,
	input  logic [63:0]     rem_i,
	input  logic [63:0]     root_i,
	output logic            valid_o,
	output lpcr_pkg::side_t side_o,
	output logic [63:0]     rem_o,
	output logic [63:0]     root_o
);
	import lpcr_pkg::*;

	localparam logic [RadW-1:0] Bit = RadW'(1) << (62 - 2 * K);

	logic [RadW:0] trial;
	logic          fits;
	logic          v_q;
	side_t         side_q;
	logic [RadW-1:0] rem_q, root_q;

	assign trial = {1'b0, root_i} + {1'b0, Bit};
	assign fits  = {1'b0, rem_i} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_i;
		if (fits) begin
			rem_q  <= rem_i - trial[RadW-1:0];
			root_q <= (root_i >> 1) + Bit;
		end else begin
			rem_q  <= rem_i;
			root_q <= root_i >> 1;
		end
	end

	assign valid_o = v_q;
	assign side_o  = side_q;
	assign rem_o   = rem_q;
	assign root_o  = root_q;
endmodule

/* rtl/lpcr_cordic_stage.sv */
// One vectoring step of the elevation angle CORDIC.
// Depends on lpcr_pkg.
module lpcr_cordic_stage #(
	parameter int I = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_i,
	input  lpcr_pkg::side_t    side_i,
	input  logic signed [35:0] u_i,
	input  logic signed [35:0] v_i,
	input  logic signed [24:0] ang_i,
	output logic               valid_o,
	output lpcr_pkg::side_t    side_o,
	output logic signed [35:0] u_o,
	output logic signed [35:0] v_o,
	output logic signed [24:0] ang_o
);
	import lpcr_pkg::*;

	logic signed [CordW-1:0] du, dv;
	logic pos;
	logic v_q;
	side_t side_q;
	logic signed [CordW-1:0] u_q, vv_q;
	logic signed [AngW-1:0] ang_q;

	assign du  = v_i >>> I;
	assign dv  = u_i >>> I;
	assign pos = !v_i[CordW-1] && (v_i != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_i;
		if (pos) begin
			u_q   <= u_i + du;
			vv_q  <= v_i - dv;
			ang_q <= ang_i + $signed(ATAN_Q16[I]);
		end else begin
			u_q   <= u_i - du;
			vv_q  <= v_i + dv;
			ang_q <= ang_i - $signed(ATAN_Q16[I]);
		end
	end

	assign valid_o = v_q;
	assign side_o  = side_q;
	assign u_o     = u_q;
	assign v_o     = vv_q;
	assign ang_o   = ang_q;
endmodule

/* rtl/lidar_point_crop_and_ring_index.sv */
// Lidar point crop and ring index, top level.
// Depends on lpcr_pkg, lpcr_front, lpcr_sqrt_stage, lpcr_cordic_stage and the macro header.
//
// Use: drive point_x/y/z and end_of_cloud with start high; a point is
// transferred at each clock edge where start is high and busy is low. busy
// is always low, so one point enters every cycle with no gaps needed.
// Each point gives exactly one result, shown for one cycle with done high,
// after the point passes 5 front stages (capture, box test, squares,
// sum, range test), 32 square root stages (one root bit each), 21 CORDIC
// stages (one vectoring step each) and one output register. Throughput is
// one point per cycle.
// The receiver cannot stall; results are never held back or dropped.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once and
// belong to quiet periods with no points in flight.
// Reset clears the pipeline valid bits and loads the default box and range.
`include "lidar_point_crop_and_ring_index_macros.svh"
module lidar_point_crop_and_ring_index #(
	parameter int RINGS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	input  logic               end_of_cloud,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [23:0]        wr_data,
	output logic               done,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic signed [23:0] out_z,
	output logic [3:0]         ring_index,
	output logic               kept,
	output logic               last_point
);
	import lpcr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_x_min <= -24'sd20480;
			cfg_q.box_x_max <= 24'sd512;
			cfg_q.box_y_min <= -24'sd512;
			cfg_q.box_y_max <= 24'sd3072;
			cfg_q.max_range <= 23'd51200;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BOX_X_MIN: cfg_q.box_x_min <= wr_data;
				REG_BOX_X_MAX: cfg_q.box_x_max <= wr_data;
				REG_BOX_Y_MIN: cfg_q.box_y_min <= wr_data;
				REG_BOX_Y_MAX: cfg_q.box_y_max <= wr_data;
				REG_MAX_RANGE: cfg_q.max_range <= wr_data[22:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic  sv [SqrtSteps+1];
	side_t ss [SqrtSteps+1];
	logic [RadW-1:0] srem [SqrtSteps+1];
	logic [RadW-1:0] sroot [SqrtSteps+1];

	lpcr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.x(point_x), .y(point_y), .z(point_z), .eoc(end_of_cloud), .cfg(cfg_q),
		.valid_o(sv[0]), .side_o(ss[0]), .rad_o(srem[0])
	);
	assign sroot[0] = '0;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		lpcr_sqrt_stage #(.K(k)) u_stage (
			.clk(clk), .arst_n(arst_n),
			.valid_i(sv[k]), .side_i(ss[k]), .rem_i(srem[k]), .root_i(sroot[k]),
			.valid_o(sv[k+1]), .side_o(ss[k+1]), .rem_o(srem[k+1]), .root_o(sroot[k+1])
		);
	end

	logic  cv [CordicSteps+1];
	side_t cs [CordicSteps+1];
	logic signed [CordW-1:0] cu [CordicSteps+1];
	logic signed [CordW-1:0] cw [CordicSteps+1];
	logic signed [AngW-1:0]  ca [CordicSteps+1];

	assign cv[0] = sv[SqrtSteps];
	assign cs[0] = ss[SqrtSteps];
	assign cu[0] = {4'b0, sroot[SqrtSteps][31:0]};
	assign cw[0] = {4'b0, ss[SqrtSteps].az, 8'b0};
	assign ca[0] = '0;

	for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
		lpcr_cordic_stage #(.I(i)) u_stage (
			.clk(clk), .arst_n(arst_n),
			.valid_i(cv[i]), .side_i(cs[i]), .u_i(cu[i]), .v_i(cw[i]), .ang_i(ca[i]),
			.valid_o(cv[i+1]), .side_o(cs[i+1]), .u_o(cu[i+1]), .v_o(cw[i+1]),
			.ang_o(ca[i+1])
		);
	end

	// round the angle to whole degrees and fold negative rings upwards
	side_t fs;
	logic [AngW-1:0] ang_c, ang_r;
	logic [7:0] mag;
	logic neg, ok;
	logic signed [8:0] ring;

	always_comb begin
		fs    = cs[CordicSteps];
		ang_c = ca[CordicSteps][AngW-1] ? '0 : ca[CordicSteps];
		ang_r = ang_c + AngW'(32768);
		mag   = fs.zzero ? 8'd0 : ang_r[23:16];
		neg   = fs.zneg && (mag != 8'd0);
		ring  = neg ? 9'(RINGS - 1) - $signed({1'b0, mag}) : $signed({1'b0, mag});
		ok    = neg ? !ring[8] : (mag <= 8'(RINGS - 1));
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cv[CordicSteps];
		end
	end

	always_ff @(posedge clk) begin
		out_x      <= fs.x;
		out_y      <= fs.y;
		out_z      <= fs.z;
		last_point <= fs.eoc;
		kept       <= fs.keep && ok;
		ring_index <= (fs.keep && ok) ? ring[3:0] : 4'd0;
	end

	assign done = done_q;

	`LPCR_ASSERT_NEXT(a_done_follows_cordic, cv[CordicSteps], done)
	`LPCR_ASSERT_NEXT(a_front_feeds_sqrt, sv[0], sv[1])
	`LPCR_ASSERT_IMPLIES(a_ring_in_range, done && kept,
		(RINGS > 16) || (int'(ring_index) <= RINGS - 1))
endmodule
